// File: src/bcld_pkg.sv
// Package with the shared types and constants of the button click and long-press detector.
package bcld_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W = 16;
    localparam int unsigned CLICK_W = 8;
    localparam int unsigned CFG_ADDR_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TIME   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CLICK_WINDOW    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS_TIME = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_LOW      = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST   = 16'd40;
    localparam logic [CFG_W-1:0] CLICK_WINDOW_RST    = 16'd250;
    localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST = 16'd600;
    localparam logic             ACTIVE_LOW_RST      = 1'b1;

    // The click counter stops here.
    localparam logic [CLICK_W-1:0] CLICK_MAX = 8'd255;
    localparam logic [CLICK_W-1:0] CLICK_ONE = 8'd1;
    localparam logic [CLICK_W-1:0] CLICK_TWO = 8'd2;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] click_window;
        logic [CFG_W-1:0] long_press_time;
        logic             active_low;
    } cfg_t;

    typedef struct packed {
        logic               started;
        logic               last_raw_pressed;
        logic               stable_pressed;
        logic [TIME_W-1:0]  last_edge_time;
        logic [TIME_W-1:0]  press_start_time;
        logic [CLICK_W-1:0] pending_clicks;
        logic [TIME_W-1:0]  release_time;
        logic               long_done;
    } state_t;

    typedef struct packed {
        logic               pressed;
        logic               changed;
        logic               single_click;
        logic               double_click;
        logic               long_start;
        logic               long_end;
        logic [CLICK_W-1:0] clicks_reported;
        logic               holding;
        logic [TIME_W-1:0]  hold_time;
    } result_t;

endpackage

// File: src/bcld_eval.sv
// Combinational evaluation of one poll: next detector state and the result word.
module bcld_eval (
    input  bcld_pkg::cfg_t                  cfg,
    input  bcld_pkg::state_t                state,
    input  logic [bcld_pkg::TIME_W-1:0]     now_ms,
    input  logic                            raw_level,
    output bcld_pkg::state_t                state_next,
    output bcld_pkg::result_t               result
);

    logic                          raw;
    logic [bcld_pkg::TIME_W-1:0]   db_elapsed;
    logic [bcld_pkg::TIME_W-1:0]   held_elapsed;
    logic [bcld_pkg::TIME_W-1:0]   idle_elapsed;
    bcld_pkg::state_t              s_db;
    bcld_pkg::state_t              s_lp;
    logic                          accept;
    logic                          l_end;
    logic                          l_start;

    assign raw = cfg.active_low ? ~raw_level : raw_level;

    always_comb begin
        s_db = state;
        l_end = 1'b0;

        // Any change of the raw flag restarts the debounce timer.
        if (raw != state.last_raw_pressed) begin
            s_db.last_edge_time = now_ms;
            s_db.last_raw_pressed = raw;
        end
        db_elapsed = now_ms - s_db.last_edge_time;
        accept = (db_elapsed >= {{(bcld_pkg::TIME_W-bcld_pkg::CFG_W){1'b0}},
                                 cfg.debounce_time}) && (raw != state.stable_pressed);

        if (accept) begin
            s_db.stable_pressed = raw;
            if (raw) begin
                s_db.press_start_time = now_ms;
                s_db.long_done = 1'b0;
            end else if (!state.long_done) begin
                if (state.pending_clicks != bcld_pkg::CLICK_MAX) begin
                    s_db.pending_clicks = state.pending_clicks + 1'b1;
                end
                s_db.release_time = now_ms;
            end else begin
                l_end = 1'b1;
            end
        end

        // A long press cancels the clicks gathered so far.
        s_lp = s_db;
        l_start = 1'b0;
        held_elapsed = now_ms - s_db.press_start_time;
        if (s_db.stable_pressed && !s_db.long_done &&
            held_elapsed >= {{(bcld_pkg::TIME_W-bcld_pkg::CFG_W){1'b0}},
                             cfg.long_press_time}) begin
            s_lp.long_done = 1'b1;
            s_lp.pending_clicks = '0;
            l_start = 1'b1;
        end

        state_next = s_lp;
        result = '0;
        result.pressed = s_lp.stable_pressed;
        result.changed = accept;
        result.long_start = l_start;
        result.long_end = l_end;
        result.holding = s_lp.stable_pressed && s_lp.long_done;
        result.hold_time = s_lp.stable_pressed ? held_elapsed : '0;

        // Close the multi-click window once it has run out while released.
        idle_elapsed = now_ms - s_lp.release_time;
        if (!s_lp.stable_pressed && (s_lp.pending_clicks != '0) &&
            idle_elapsed >= {{(bcld_pkg::TIME_W-bcld_pkg::CFG_W){1'b0}},
                             cfg.click_window}) begin
            result.clicks_reported = s_lp.pending_clicks;
            result.single_click = (s_lp.pending_clicks == bcld_pkg::CLICK_ONE);
            result.double_click = (s_lp.pending_clicks == bcld_pkg::CLICK_TWO);
            state_next.pending_clicks = '0;
        end

        // The first poll after reset only seeds the debounced state.
        if (!state.started) begin
            state_next = state;
            state_next.started = 1'b1;
            state_next.last_raw_pressed = raw;
            state_next.stable_pressed = raw;
            state_next.last_edge_time = now_ms;
            state_next.press_start_time = now_ms;
            result = '0;
            result.pressed = raw;
        end
    end

endmodule

// File: src/button_click_longpress_detector_top.sv
// Top level of the button debounce, multi-click and long-press detector.
//
//   Channel   Direction  Handshake            Word
//   s_        in         s_valid / s_ready    s_now_ms, s_raw_level (one poll)
//   m_        out        m_valid / m_ready    pressed, changed, click and long-press
//                                             pulses, clicks_reported, holding, hold_time
//   cfg_      in         cfg_wr_en            cfg_addr, cfg_wdata
//
// Every poll word yields exactly one result word. The block takes one word per cycle
// while the result side is not stalled. A word is held in the input register; the
// detector state and the result register are then updated together when it moves on.
// The input register and the result register each advance when the stage after them
// is empty or is being drained, so a stall on m_ready holds one result and one poll.
// Reset (aresetn low, synchronous) empties both stages, clears the detector state and
// loads the configuration defaults; the first poll after reset only seeds the state.
module button_click_longpress_detector_top (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bcld_pkg::TIME_W-1:0]       s_now_ms,
    input  logic                              s_raw_level,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_pressed,
    output logic                              m_changed,
    output logic                              m_single_click,
    output logic                              m_double_click,
    output logic                              m_long_start,
    output logic                              m_long_end,
    output logic [bcld_pkg::CLICK_W-1:0]      m_clicks_reported,
    output logic                              m_holding,
    output logic [bcld_pkg::TIME_W-1:0]       m_hold_time,

    input  logic                              cfg_wr_en,
    input  logic [bcld_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bcld_pkg::CFG_W-1:0]        cfg_wdata
);

    // Configuration registers.
    bcld_pkg::cfg_t                 cfg_reg;

    // Input stage.
    logic                           in_valid_reg;
    logic [bcld_pkg::TIME_W-1:0]    now_reg;
    logic                           level_reg;

    // Detector state and result stage.
    bcld_pkg::state_t               state_reg;
    bcld_pkg::state_t               state_next;
    bcld_pkg::result_t              result_reg;
    bcld_pkg::result_t              result_next;
    logic                           out_valid_reg;

    logic                           out_free;
    logic                           advance;

    // The result stage can take a word when it is empty or its word leaves now.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    // The input stage can take a word when it is empty or its word moves on now.
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time   <= bcld_pkg::DEBOUNCE_TIME_RST;
            cfg_reg.click_window    <= bcld_pkg::CLICK_WINDOW_RST;
            cfg_reg.long_press_time <= bcld_pkg::LONG_PRESS_TIME_RST;
            cfg_reg.active_low      <= bcld_pkg::ACTIVE_LOW_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                bcld_pkg::REG_DEBOUNCE_TIME:   cfg_reg.debounce_time   <= cfg_wdata;
                bcld_pkg::REG_CLICK_WINDOW:    cfg_reg.click_window    <= cfg_wdata;
                bcld_pkg::REG_LONG_PRESS_TIME: cfg_reg.long_press_time <= cfg_wdata;
                bcld_pkg::REG_ACTIVE_LOW:      cfg_reg.active_low      <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg   <= s_now_ms;
            level_reg <= s_raw_level;
        end
    end

    bcld_eval u_eval (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .now_ms     (now_reg),
        .raw_level  (level_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // The detector state moves only when a poll moves into the result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_pressed         = result_reg.pressed;
    assign m_changed         = result_reg.changed;
    assign m_single_click    = result_reg.single_click;
    assign m_double_click    = result_reg.double_click;
    assign m_long_start      = result_reg.long_start;
    assign m_long_end        = result_reg.long_end;
    assign m_clicks_reported = result_reg.clicks_reported;
    assign m_holding         = result_reg.holding;
    assign m_hold_time       = result_reg.hold_time;

    // A long press that is being held always shows as pressed.
    a_holding_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_holding |-> m_pressed)
        else $error("holding reported while not pressed");

    // Hold time is only counted while the button is down.
    a_hold_time_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_pressed |-> m_hold_time == '0)
        else $error("hold time nonzero while released");

    // Click pulses agree with the reported count.
    a_single_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_single_click |-> m_clicks_reported == bcld_pkg::CLICK_ONE)
        else $error("single click without a count of one");

    // A long press start leaves the detector holding.
    a_long_start_holding: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_long_start |-> m_holding && m_clicks_reported == '0)
        else $error("long press start without holding");

    // A word waiting in the result stage is not overwritten while stalled.
    a_result_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hold_time) && $stable(m_pressed))
        else $error("result word changed under stall");

endmodule

// File: bench/button_click_longpress_detector_top_tb.sv
// Self-checking testbench for the button debounce, multi-click and long-press detector.
`timescale 1ns / 1ps

module button_click_longpress_detector_top_tb;

    // Cycles with no word accepted on either channel before the run is declared hung.
    // A correct run never comes close: the longest quiet spell is a register update
    // or a random stall on m_ready.
    localparam int STALL_LIMIT = 2000;

    // One poll as it travels on the input channel.
    typedef struct packed {
        logic [bcld_pkg::TIME_W-1:0] now_ms;
        logic                        level;
    } poll_word_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;

    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [bcld_pkg::TIME_W-1:0]     s_now_ms = '0;
    logic                            s_raw_level = 1'b0;

    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic                            m_pressed;
    logic                            m_changed;
    logic                            m_single_click;
    logic                            m_double_click;
    logic                            m_long_start;
    logic                            m_long_end;
    logic [bcld_pkg::CLICK_W-1:0]    m_clicks_reported;
    logic                            m_holding;
    logic [bcld_pkg::TIME_W-1:0]     m_hold_time;

    logic                            cfg_wr_en = 1'b0;
    logic [bcld_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [bcld_pkg::CFG_W-1:0]      cfg_wdata = '0;

    // Polls waiting for the driver, and the results the detector still owes us.
    poll_word_t                      poll_q[$];
    bcld_pkg::result_t               owed_events[$];

    // The bench's own copy of the detector: its registers and its state.
    bcld_pkg::cfg_t                  cfg_shadow;
    bcld_pkg::state_t                det;

    // Running time base of the generated polls; it wraps like the real millisecond tick.
    logic [bcld_pkg::TIME_W-1:0]     clock_ms = '0;

    int                              polls_owed = 0;
    int                              polls_taken = 0;
    int                              results_seen = 0;
    int                              mismatches = 0;
    int                              stall_cycles = 0;
    int                              singles = 0;
    int                              doubles = 0;
    int                              long_presses = 0;
    int                              max_reported = 0;

    // High for one sampled edge when the poll word on the bus was taken there.
    logic                            poll_sent = 1'b0;
    // A long stretch of the run where neither side ever holds back.
    logic                            calm;

    assign calm = (polls_taken >= 200) && (polls_taken < 360);

    button_click_longpress_detector_top i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_now_ms          (s_now_ms),
        .s_raw_level       (s_raw_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pressed         (m_pressed),
        .m_changed         (m_changed),
        .m_single_click    (m_single_click),
        .m_double_click    (m_double_click),
        .m_long_start      (m_long_start),
        .m_long_end        (m_long_end),
        .m_clicks_reported (m_clicks_reported),
        .m_holding         (m_holding),
        .m_hold_time       (m_hold_time),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicts the result word of one poll and advances the detector copy.
    // The order matters: debounce first, then the long-press check on the
    // updated state, then the click window.
    function automatic bcld_pkg::result_t debounce_and_classify(
            input logic [bcld_pkg::TIME_W-1:0] now, input logic level);
        bcld_pkg::result_t ev;
        logic              raw;
        ev  = '0;
        raw = cfg_shadow.active_low ? ~level : level;

        // The first poll after reset only seeds the state and raises no event.
        if (!det.started) begin
            det.started          = 1'b1;
            det.last_raw_pressed = raw;
            det.stable_pressed   = raw;
            det.last_edge_time   = now;
            det.press_start_time = now;
            ev.pressed           = raw;
            return ev;
        end

        // Any raw change restarts the debounce timer.
        if (raw != det.last_raw_pressed) begin
            det.last_edge_time   = now;
            det.last_raw_pressed = raw;
        end
        if ((now - det.last_edge_time) >= cfg_shadow.debounce_time &&
            raw != det.stable_pressed) begin
            det.stable_pressed = raw;
            ev.changed         = 1'b1;
            if (raw) begin
                det.press_start_time = now;
                det.long_done        = 1'b0;
            end else if (!det.long_done) begin
                // A short press ends: count it, the counter stops at its maximum.
                if (det.pending_clicks < bcld_pkg::CLICK_MAX) begin
                    det.pending_clicks = det.pending_clicks + 1'b1;
                end
                det.release_time = now;
            end else begin
                ev.long_end = 1'b1;
            end
        end

        // A press held long enough turns long and throws away the pending clicks.
        if (det.stable_pressed && !det.long_done &&
            (now - det.press_start_time) >= cfg_shadow.long_press_time) begin
            det.long_done      = 1'b1;
            det.pending_clicks = '0;
            ev.long_start      = 1'b1;
        end

        // The window closes: report the count, with a pulse only for one or two clicks.
        if (!det.stable_pressed && det.pending_clicks != '0 &&
            (now - det.release_time) >= cfg_shadow.click_window) begin
            ev.clicks_reported = det.pending_clicks;
            ev.single_click    = (det.pending_clicks == bcld_pkg::CLICK_ONE);
            ev.double_click    = (det.pending_clicks == bcld_pkg::CLICK_TWO);
            det.pending_clicks = '0;
        end

        ev.pressed   = det.stable_pressed;
        ev.holding   = det.stable_pressed && det.long_done;
        ev.hold_time = det.stable_pressed ? (now - det.press_start_time) : '0;
        return ev;
    endfunction

    function automatic void check_field(input string field,
                                        input logic [bcld_pkg::TIME_W-1:0] want,
                                        input logic [bcld_pkg::TIME_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Result %0d, field %s: expected 0x%0h, got 0x%0h",
                         results_seen, field, want, got);
            end
        end
    endfunction

    // Appends one poll dt milliseconds after the previous one.
    function automatic void queue_poll(input int unsigned dt, input logic level);
        poll_word_t p;
        clock_ms  = clock_ms + dt;
        p.now_ms  = clock_ms;
        p.level   = level;
        poll_q.push_back(p);
        polls_owed++;
    endfunction

    // Appends one random gesture shaped by the current register settings. Most are
    // real presses with contact bounce, short or long, followed by a gap that either
    // keeps the click window open or lets it close. The rest are time jumps and
    // presses that bounce but never settle.
    function automatic void queue_gesture();
        int unsigned db;
        int unsigned win;
        int unsigned lp;
        int unsigned hold;
        int unsigned steps;
        int unsigned kind;
        logic        down;
        logic        up;
        db   = 32'(cfg_shadow.debounce_time);
        win  = 32'(cfg_shadow.click_window);
        lp   = 32'(cfg_shadow.long_press_time);
        down = ~cfg_shadow.active_low;
        up   = cfg_shadow.active_low;
        kind = $urandom_range(9, 0);

        if (kind == 0) begin
            // Noise: a jump anywhere in the 32-bit time range, random level.
            queue_poll($urandom(), 1'($urandom_range(1, 0)));
            return;
        end
        if (kind == 1) begin
            // Broken press: bounce that never stays put long enough.
            repeat ($urandom_range(3, 1)) begin
                queue_poll($urandom_range(db / 2, 0), down);
                queue_poll($urandom_range(db / 2, 0), up);
            end
            return;
        end

        repeat ($urandom_range(3, 0)) begin
            queue_poll($urandom_range(db / 2, 0), down);
            queue_poll($urandom_range(db / 2, 0), up);
        end
        queue_poll($urandom_range(3, 0), down);
        queue_poll(db + $urandom_range(2, 0), down);

        if (kind >= 7) begin
            hold = lp + $urandom_range(lp / 2 + 5, 0);
        end else begin
            hold = $urandom_range(lp / 3, 0);
        end
        steps = $urandom_range(3, 1);
        repeat (steps) begin
            queue_poll(hold / steps, down);
        end

        repeat ($urandom_range(2, 0)) begin
            queue_poll($urandom_range(db / 2, 0), up);
            queue_poll($urandom_range(db / 2, 0), down);
        end
        queue_poll($urandom_range(3, 0), up);
        queue_poll(db + $urandom_range(2, 0), up);

        if ($urandom_range(1, 0) == 1) begin
            queue_poll($urandom_range(win / 2, 0), up);
        end else begin
            queue_poll(win + $urandom_range(20, 0), up);
        end
    endfunction

    // Register writes are driven on the falling edge; the shadow copy follows once
    // the write edge has passed, while nothing is in flight.
    task automatic write_reg(input logic [bcld_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [bcld_pkg::CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            bcld_pkg::REG_DEBOUNCE_TIME:   cfg_shadow.debounce_time   = val;
            bcld_pkg::REG_CLICK_WINDOW:    cfg_shadow.click_window    = val;
            bcld_pkg::REG_LONG_PRESS_TIME: cfg_shadow.long_press_time = val;
            bcld_pkg::REG_ACTIVE_LOW:      cfg_shadow.active_low      = val[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [bcld_pkg::CFG_W-1:0] debounce,
                                input logic [bcld_pkg::CFG_W-1:0] window,
                                input logic [bcld_pkg::CFG_W-1:0] long_press,
                                input logic low_pressed);
        write_reg(bcld_pkg::REG_DEBOUNCE_TIME, debounce);
        write_reg(bcld_pkg::REG_CLICK_WINDOW, window);
        write_reg(bcld_pkg::REG_LONG_PRESS_TIME, long_press);
        write_reg(bcld_pkg::REG_ACTIVE_LOW, {{(bcld_pkg::CFG_W-1){1'b0}}, low_pressed});
        @(posedge aclk);
    endtask

    // Waits until every queued poll was taken and every result came back, then lets
    // the two-stage pipeline settle. Returns on a rising edge so that the next batch
    // of polls is queued away from the driver's falling edge.
    task automatic await_quiet();
        while (polls_owed != 0 || owed_events.size() != 0) begin
            @(negedge aclk);
        end
        repeat (3) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Poll driver. A word on the bus stays until it is taken; a new one goes up on
    // the falling edge after, unless this cycle is picked to idle.
    always @(negedge aclk) begin : poll_feed
        poll_word_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || poll_sent) begin
            if (poll_q.size() != 0 && (calm || $urandom_range(99, 0) >= 32)) begin
                nxt          = poll_q.pop_front();
                s_valid     <= 1'b1;
                s_now_ms    <= nxt.now_ms;
                s_raw_level <= nxt.level;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // The result side holds back at random too, except in the calm stretch.
    always @(negedge aclk) begin : result_drain
        m_ready <= calm || ($urandom_range(99, 0) >= 32);
    end

    // Monitor: every poll taken gets a prediction; every result taken is checked
    // against the oldest one still owed.
    always @(posedge aclk) begin : observe
        bcld_pkg::result_t seen;
        bcld_pkg::result_t want;
        if (!aresetn) begin
            poll_sent <= 1'b0;
        end else begin
            poll_sent <= s_valid && s_ready;
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end

            if (s_valid && s_ready) begin
                owed_events.push_back(debounce_and_classify(s_now_ms, s_raw_level));
                polls_owed--;
                polls_taken++;
            end

            if (m_valid && m_ready) begin
                results_seen++;
                seen = '{m_pressed, m_changed, m_single_click, m_double_click, m_long_start,
                         m_long_end, m_clicks_reported, m_holding, m_hold_time};
                if (owed_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result %0d arrived with no poll waiting for it", results_seen);
                    end
                end else begin
                    want = owed_events.pop_front();
                    check_field("pressed", 32'(want.pressed), 32'(seen.pressed));
                    check_field("changed", 32'(want.changed), 32'(seen.changed));
                    check_field("single_click", 32'(want.single_click),
                                32'(seen.single_click));
                    check_field("double_click", 32'(want.double_click),
                                32'(seen.double_click));
                    check_field("long_start", 32'(want.long_start), 32'(seen.long_start));
                    check_field("long_end", 32'(want.long_end), 32'(seen.long_end));
                    check_field("clicks_reported", 32'(want.clicks_reported),
                                32'(seen.clicks_reported));
                    check_field("holding", 32'(want.holding), 32'(seen.holding));
                    check_field("hold_time", want.hold_time, seen.hold_time);
                end
                if (seen.single_click) singles++;
                if (seen.double_click) doubles++;
                if (seen.long_start) long_presses++;
                if (seen.clicks_reported > max_reported) begin
                    max_reported = int'(seen.clicks_reported);
                end
            end
        end
    end

    // Hang detection: too long without a word moving on either channel.
    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("No word moved for %0d cycles, giving up", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        det        = '0;
        cfg_shadow = '{bcld_pkg::DEBOUNCE_TIME_RST, bcld_pkg::CLICK_WINDOW_RST,
                       bcld_pkg::LONG_PRESS_TIME_RST, bcld_pkg::ACTIVE_LOW_RST};
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset settings: low level means pressed, 40 ms debounce,
        // 250 ms click window, 600 ms long press. The time base starts just below the
        // wrap point so that the first gestures straddle it.
        clock_ms = 32'hFFFF_FF00;
        queue_poll(0, 1'b0);     // button already held at start-up: seeds pressed
        queue_poll(10, 1'b1);    // raw release, still bouncing
        queue_poll(50, 1'b1);    // release accepted, one click pending
        queue_poll(300, 1'b1);   // window runs out across the wrap: single click
        // Three quick clicks: the count goes out without a click pulse.
        repeat (3) begin
            queue_poll(10, 1'b0);
            queue_poll(50, 1'b0);
            queue_poll(20, 1'b1);
            queue_poll(50, 1'b1);
        end
        queue_poll(300, 1'b1);
        // Long press: start pulse while held, end pulse on release, no click counted.
        queue_poll(10, 1'b0);
        queue_poll(50, 1'b0);
        queue_poll(600, 1'b0);
        queue_poll(10, 1'b1);
        queue_poll(50, 1'b1);
        await_quiet();

        // Random gestures at the reset settings.
        while (poll_q.size() < 100) queue_gesture();
        await_quiet();

        // All thresholds zero and high level means pressed: every change is taken at
        // once and every press turns long on its first poll.
        program_regs('0, '0, '0, 1'b0);
        while (poll_q.size() < 70) queue_gesture();
        await_quiet();

        // All registers at their top values.
        program_regs('1, '1, '1, 1'b1);
        while (poll_q.size() < 70) queue_gesture();
        await_quiet();

        // Click counter saturation: no debounce and a window that never closes during
        // the burst, so the 260 short presses run the click counter up to its limit.
        program_regs('0, '1, 16'd1000, 1'b0);
        queue_poll(70000, 1'b0);
        queue_poll(70000, 1'b0);
        repeat (260) begin
            queue_poll($urandom_range(3, 0), 1'b1);
            queue_poll($urandom_range(3, 0), 1'b0);
        end
        queue_poll(70000, 1'b0);
        await_quiet();

        // A couple of random settings in the ranges a real button would use.
        repeat (2) begin
            program_regs(16'($urandom_range(100, 0)), 16'($urandom_range(600, 0)),
                         16'($urandom_range(1500, 0)), 1'($urandom_range(1, 0)));
            while (poll_q.size() < 70) queue_gesture();
            await_quiet();
        end

        // Give a stray result time to show up before the verdict.
        repeat (6) @(negedge aclk);

        $display("Checked %0d results for %0d polls over six register settings, %0d mismatches.",
                 results_seen, polls_taken, mismatches);
        $display("Saw %0d single and %0d double clicks, %0d long presses, top count %0d.",
                 singles, doubles, long_presses, max_reported);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
src/bcld_pkg.sv
src/bcld_eval.sv
src/button_click_longpress_detector_top.sv
bench/button_click_longpress_detector_top_tb.sv
